// ----- hdl/gpdst_pkg.sv -----
`default_nettype none

package gpdst_pkg;

   // Table geometry.
   localparam int CAPACITY    = 64;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int COORD_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int DIR_COUNT   = 4;
   localparam int DIRS_BITS   = DIR_COUNT * STATUS_BITS;

   typedef enum logic [0:0] {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // One stored grid point: its key and the status of all four directions.
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [DIRS_BITS-1:0]  dirs;
   } entry_type;

   // Access request from the controller to the entry memory.
   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
   } mem_ctrl_type;

   // Replace the status field of one direction.
   function automatic logic [DIRS_BITS-1:0] set_dir(
      input logic [DIRS_BITS-1:0]   dirs,
      input logic [1:0]             dir,
      input logic [STATUS_BITS-1:0] status
   );
      logic [DIRS_BITS-1:0] result;
      result = dirs;
      for (int i = 0; i < DIR_COUNT; i++) begin
         if (dir == 2'(i)) begin
            result[i*STATUS_BITS +: STATUS_BITS] = status;
         end
      end
      return result;
   endfunction

   // Pick the status field of one direction.
   function automatic logic [STATUS_BITS-1:0] get_dir(
      input logic [DIRS_BITS-1:0] dirs,
      input logic [1:0]           dir
   );
      logic [STATUS_BITS-1:0] result;
      result = '0;
      for (int i = 0; i < DIR_COUNT; i++) begin
         if (dir == 2'(i)) begin
            result = dirs[i*STATUS_BITS +: STATUS_BITS];
         end
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/gpdst_mem.sv -----
`default_nettype none

module gpdst_mem
   import gpdst_pkg::*;
(
   input  wire logic         clock,
   input  wire mem_ctrl_type ctrl,
   output      entry_type    rd_data_ff
);

   // Entry store: one write port, one registered read port.
   entry_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/grid_point_direction_status_table_core.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  opcode, x_coord, y_coord, dir_sel, status_in
// rsp_      out        rsp_valid / rsp_ready  status_out, found, table_full
//
// One item at a time. The entry memory is read one entry per cycle through its
// single read port, in insertion order. Reset clears the point count and the
// control state; memory contents are not cleared, since only entries below the
// count are ever read.
// A result waits in the output register; the next item is taken meanwhile.

module grid_point_direction_status_table_core
   import gpdst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_opcode,
   input  wire logic [15:0] req_x_coord,
   input  wire logic [15:0] req_y_coord,
   input  wire logic [1:0]  req_dir_sel,
   input  wire logic [1:0]  req_status_in,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status_out,
   output      logic        rsp_found,
   output      logic        rsp_table_full
);

   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

   state_type               state_ff, state_in;
   opcode_type              op_ff, op_in;
   logic [COORD_BITS-1:0]   x_ff, x_in;
   logic [COORD_BITS-1:0]   y_ff, y_in;
   logic [1:0]              dir_ff, dir_in;
   logic [STATUS_BITS-1:0]  st_ff, st_in;
   logic [CNT_BITS-1:0]     scan_ff, scan_in;
   logic                    pend_ff, pend_in;
   logic [IDX_BITS-1:0]     pend_idx_ff, pend_idx_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic                    res_found_ff, res_found_in;
   logic                    res_full_ff, res_full_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_full_ff, rsp_full_in;

   mem_ctrl_type            mem_ctrl;
   entry_type               rd_entry;
   logic                    issue;
   logic                    match;

   gpdst_mem u_mem (
      .clock      (clock),
      .ctrl       (mem_ctrl),
      .rd_data_ff (rd_entry)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status_out = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_table_full = rsp_full_ff;

   // A read is issued while stored entries remain; the previous read is compared.
   assign issue = (scan_ff < count_ff);
   assign match = pend_ff && (rd_entry.x == x_ff) && (rd_entry.y == y_ff);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      dir_ff        <= dir_in;
      st_ff         <= st_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_full_ff   <= res_full_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_full_ff   <= rsp_full_in;
   end

   // Next state, memory accesses and results.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      dir_in        = dir_ff;
      st_in         = st_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_full_in   = res_full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_full_in   = rsp_full_ff;

      mem_ctrl         = '0;
      mem_ctrl.rd_addr = scan_ff[IDX_BITS-1:0];
      mem_ctrl.wr_data = '{x: x_ff, y: y_ff, dirs: set_dir('0, dir_ff, st_ff)};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = opcode_type'(req_opcode);
               x_in     = req_x_coord[COORD_BITS-1:0];
               y_in     = req_y_coord[COORD_BITS-1:0];
               dir_in   = req_dir_sel;
               st_in    = req_status_in[STATUS_BITS-1:0];
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            mem_ctrl.rd_en = issue;
            pend_idx_in    = scan_ff[IDX_BITS-1:0];
            pend_in        = issue && !match;
            if (issue) begin
               scan_in = scan_ff + CNT_BITS'(1);
            end

            if (match) begin
               // Key found: update the direction in place or report it.
               res_found_in  = 1'b1;
               res_full_in   = 1'b0;
               res_status_in = '0;
               if (op_ff == OP_RECORD) begin
                  mem_ctrl.wr_en   = 1'b1;
                  mem_ctrl.wr_addr = pend_idx_ff;
                  mem_ctrl.wr_data = '{x: x_ff, y: y_ff,
                                       dirs: set_dir(rd_entry.dirs, dir_ff, st_ff)};
               end else begin
                  res_status_in = 2'(get_dir(rd_entry.dirs, dir_ff));
               end
               state_in = ST_DONE;
            end else if (!issue && !pend_ff) begin
               // Key absent: a record appends the point if there is room; a query reports not found.
               res_found_in  = 1'b0;
               res_status_in = '0;
               res_full_in   = 1'b0;
               if (op_ff == OP_RECORD) begin
                  if (count_ff != FULL_COUNT) begin
                     mem_ctrl.wr_en   = 1'b1;
                     mem_ctrl.wr_addr = count_ff[IDX_BITS-1:0];
                     count_in         = count_ff + CNT_BITS'(1);
                  end else begin
                     res_full_in = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_full_in   = res_full_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The point count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("point count exceeds capacity");

   // The count moves by at most one, and only at the end of a search.
   assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |->
         count_ff == $past(count_ff) + CNT_BITS'(1) && $past(state_ff) == ST_SCAN)
      else $error("point count changed unexpectedly");

   // A dropped point was never found in the table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_full_ff |-> !rsp_found_ff)
      else $error("table full reported for a found point");

   // A memory write only happens while finishing a record.
   assert property (@(posedge clock) disable iff (reset)
      mem_ctrl.wr_en |-> state_ff == ST_SCAN && op_ff == OP_RECORD)
      else $error("entry write outside a record");

   // A hit in the search always leads to the result stage with found set.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && match |=> state_ff == ST_DONE && res_found_ff)
      else $error("hit not carried to the result stage");

endmodule

`default_nettype wire
